// ----- hw/rtl/cd_msf_time_add_sub_top_defines.svh -----
// cd_msf_time_add_sub_top_defines.svh: assertion macros for the msf time arithmetic rtl
// no dependencies; SYNTH empties the macros for synthesis
`ifndef CD_MSF_TIME_ADD_SUB_TOP_DEFINES_SVH
`define CD_MSF_TIME_ADD_SUB_TOP_DEFINES_SVH

`ifndef SYNTH
`define CD_MSF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cd_msf assertion failed");
`define CD_MSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cd_msf assertion failed");
`else
`define CD_MSF_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define CD_MSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/cd_msf_pkg.sv -----
// cd_msf_pkg: field widths, op codes, disc timing constants, reciprocals and stage types
// used by every module of the msf time arithmetic block; no dependencies
package cd_msf_pkg;

    localparam int OP_W  = 2;
    localparam int MIN_W = 8;
    localparam int SEC_W = 6;
    localparam int FRM_W = 7;
    localparam int SMP_W = 10;
    localparam int CNT_W = 28;

    localparam logic [OP_W-1:0] OP_ADD_POS = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB_POS = 2'd1;
    localparam logic [OP_W-1:0] OP_ADD_CNT = 2'd2;
    localparam logic [OP_W-1:0] OP_SUB_CNT = 2'd3;

    localparam longint unsigned SAMPLES_PER_FRAME  = 64'd588;
    localparam longint unsigned FRAMES_PER_SECOND  = 64'd75;
    localparam longint unsigned SECONDS_PER_MINUTE = 64'd60;
    localparam longint unsigned MINUTE_MODULUS     = 64'd256;
    localparam longint unsigned SAMPLES_PER_SECOND = SAMPLES_PER_FRAME * FRAMES_PER_SECOND;
    localparam longint unsigned SAMPLES_PER_MINUTE = SAMPLES_PER_SECOND * SECONDS_PER_MINUTE;
    localparam longint unsigned PERIOD             = SAMPLES_PER_MINUTE * MINUTE_MODULUS;

    // largest linear value that any field pattern can give
    localparam longint unsigned LIN_MAX =
        (64'd1 << MIN_W) - 1 * SAMPLES_PER_MINUTE * 0 - 1 == 0 ? 64'd0 :
        ((64'd1 << MIN_W) - 64'd1) * SAMPLES_PER_MINUTE
        + ((64'd1 << SEC_W) - 64'd1) * SAMPLES_PER_SECOND
        + ((64'd1 << FRM_W) - 64'd1) * SAMPLES_PER_FRAME
        + ((64'd1 << SMP_W) - 64'd1);
    localparam int LIN_W = $clog2(LIN_MAX + 64'd1);
    // signed sum or difference of two linear values
    localparam int SUM_W = LIN_W + 2;

    // 2^64 mod period: a negative 64-bit difference folds back by this
    localparam longint unsigned WRAP_OFS = ((64'hFFFF_FFFF_FFFF_FFFF % PERIOD) + 64'd1) % PERIOD;

    // reciprocal divisions, exact for every numerator of the given width
    localparam int              QDIV_SH     = 2;
    localparam longint unsigned QUARTER_FRM = SAMPLES_PER_FRAME >> QDIV_SH;
    localparam longint unsigned QUARTER_SEC = SAMPLES_PER_SECOND >> QDIV_SH;
    localparam int              MDIV_SH     = 4;
    localparam longint unsigned SIXTEENTH_MIN = SAMPLES_PER_MINUTE >> MDIV_SH;

    localparam int CNT_NUM_W = CNT_W - QDIV_SH;
    localparam int RCP_CNT_SH = CNT_NUM_W + $clog2(QUARTER_FRM);
    localparam longint unsigned RCP_CNT = ((64'd1 << RCP_CNT_SH) + QUARTER_FRM - 64'd1)
                                          / QUARTER_FRM;
    localparam int RCP_CNT_W = $clog2(RCP_CNT + 64'd1);
    localparam int CNT_PROD_W = CNT_NUM_W + RCP_CNT_W;
    localparam int CNT_Q_W = $clog2(((64'd1 << CNT_W) / SAMPLES_PER_FRAME) + 64'd1);

    localparam int MIN_NUM_W = LIN_W - MDIV_SH;
    localparam int RCP_MIN_SH = MIN_NUM_W + $clog2(SIXTEENTH_MIN);
    localparam longint unsigned RCP_MIN = ((64'd1 << RCP_MIN_SH) + SIXTEENTH_MIN - 64'd1)
                                          / SIXTEENTH_MIN;
    localparam int MIN_PROD_W = MIN_NUM_W + $clog2(RCP_MIN + 64'd1);

    localparam int QNUM_W = LIN_W - QDIV_SH;
    localparam int RCP_SEC_SH = QNUM_W + $clog2(QUARTER_SEC);
    localparam longint unsigned RCP_SEC = ((64'd1 << RCP_SEC_SH) + QUARTER_SEC - 64'd1)
                                          / QUARTER_SEC;
    localparam int SEC_PROD_W = QNUM_W + $clog2(RCP_SEC + 64'd1);
    localparam int RCP_FRM_SH = QNUM_W + $clog2(QUARTER_FRM);
    localparam longint unsigned RCP_FRM = ((64'd1 << RCP_FRM_SH) + QUARTER_FRM - 64'd1)
                                          / QUARTER_FRM;
    localparam int FRM_PROD_W = QNUM_W + $clog2(RCP_FRM + 64'd1);

    // whole seconds and whole frames within one period
    localparam int TOTSEC_W = $clog2(MINUTE_MODULUS * SECONDS_PER_MINUTE);
    localparam int TOTFRM_W = $clog2(MINUTE_MODULUS * SECONDS_PER_MINUTE * FRAMES_PER_SECOND);

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             frame_only;
        logic [MIN_W-1:0] a_minute;
        logic [SEC_W-1:0] a_second;
        logic [FRM_W-1:0] a_frame;
        logic [SMP_W-1:0] a_sample;
        logic [MIN_W-1:0] b_minute;
        logic [SEC_W-1:0] b_second;
        logic [FRM_W-1:0] b_frame;
        logic [SMP_W-1:0] b_sample;
        logic [CNT_W-1:0] sample_count;
    } in_t;

    typedef struct packed {
        logic             sub;
        logic [LIN_W-1:0] left;
        logic [LIN_W-1:0] right;
    } lin_t;

    typedef struct packed {
        logic             wrap;
        logic [LIN_W-1:0] r;
    } red_t;

    typedef struct packed {
        logic [MIN_W-1:0] minute;
        logic [SEC_W-1:0] second;
        logic [FRM_W-1:0] frame;
        logic [SMP_W-1:0] sample;
        logic             wrap;
    } res_t;

endpackage

// ----- hw/rtl/cd_msf_lin.sv -----
// cd_msf_lin: turns both operands into linear sample counts over two register stages
// depends on cd_msf_pkg
module cd_msf_lin (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cd_msf_pkg::in_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output cd_msf_pkg::lin_t out_data
);
    import cd_msf_pkg::*;

    logic en1;
    logic en2;
    logic v1_reg;
    logic v2_reg;

    logic             sub_next;
    logic             sub_reg;
    logic             use_cnt_next;
    logic             use_cnt_reg;
    logic             fonly_reg;
    logic [LIN_W-1:0] a_min_p_next;
    logic [LIN_W-1:0] a_sec_p_next;
    logic [LIN_W-1:0] a_frm_p_next;
    logic [LIN_W-1:0] a_smp_next;
    logic [LIN_W-1:0] b_min_p_next;
    logic [LIN_W-1:0] b_sec_p_next;
    logic [LIN_W-1:0] b_frm_p_next;
    logic [LIN_W-1:0] b_smp_next;
    logic [LIN_W-1:0] a_min_p_reg;
    logic [LIN_W-1:0] a_sec_p_reg;
    logic [LIN_W-1:0] a_frm_p_reg;
    logic [LIN_W-1:0] a_smp_reg;
    logic [LIN_W-1:0] b_min_p_reg;
    logic [LIN_W-1:0] b_sec_p_reg;
    logic [LIN_W-1:0] b_frm_p_reg;
    logic [LIN_W-1:0] b_smp_reg;
    logic [CNT_PROD_W-1:0] cnt_prod;
    logic [CNT_Q_W-1:0]    cnt_q_next;
    logic [CNT_Q_W-1:0]    cnt_q_reg;
    logic [CNT_W-1:0]      cnt_reg;

    logic [LIN_W-1:0] pos_right;
    logic [LIN_W-1:0] cnt_trunc;
    logic [LIN_W-1:0] cnt_right;
    lin_t             lin_next;
    lin_t             lin_reg;

    assign en2       = !v2_reg || out_ready;
    assign en1       = !v1_reg || en2;
    assign in_ready  = en1;
    assign out_valid = v2_reg;
    assign out_data  = lin_reg;

    always_comb
    begin
        unique case (in_data.op)
            OP_ADD_POS:
            begin
                sub_next     = 1'b0;
                use_cnt_next = 1'b0;
            end
            OP_SUB_POS:
            begin
                sub_next     = 1'b1;
                use_cnt_next = 1'b0;
            end
            OP_ADD_CNT:
            begin
                sub_next     = 1'b0;
                use_cnt_next = 1'b1;
            end
            OP_SUB_CNT:
            begin
                sub_next     = 1'b1;
                use_cnt_next = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        a_min_p_next = LIN_W'(in_data.a_minute) * LIN_W'(SAMPLES_PER_MINUTE);
        a_sec_p_next = LIN_W'(in_data.a_second) * LIN_W'(SAMPLES_PER_SECOND);
        a_frm_p_next = LIN_W'(in_data.a_frame) * LIN_W'(SAMPLES_PER_FRAME);
        a_smp_next   = in_data.frame_only ? '0 : LIN_W'(in_data.a_sample);
        b_min_p_next = LIN_W'(in_data.b_minute) * LIN_W'(SAMPLES_PER_MINUTE);
        b_sec_p_next = LIN_W'(in_data.b_second) * LIN_W'(SAMPLES_PER_SECOND);
        b_frm_p_next = LIN_W'(in_data.b_frame) * LIN_W'(SAMPLES_PER_FRAME);
        b_smp_next   = in_data.frame_only ? '0 : LIN_W'(in_data.b_sample);
        // whole frames in the count: quarter count times reciprocal of 147
        cnt_prod     = CNT_PROD_W'(in_data.sample_count[CNT_W-1:QDIV_SH])
                       * CNT_PROD_W'(RCP_CNT);
        cnt_q_next   = cnt_prod[RCP_CNT_SH +: CNT_Q_W];
    end

    always_comb
    begin
        pos_right = b_min_p_reg + b_sec_p_reg + b_frm_p_reg + b_smp_reg;
        cnt_trunc = LIN_W'(cnt_q_reg) * LIN_W'(SAMPLES_PER_FRAME);
        cnt_right = fonly_reg ? cnt_trunc : LIN_W'(cnt_reg);
        lin_next.sub   = sub_reg;
        lin_next.left  = a_min_p_reg + a_sec_p_reg + a_frm_p_reg + a_smp_reg;
        lin_next.right = use_cnt_reg ? cnt_right : pos_right;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            sub_reg     <= sub_next;
            use_cnt_reg <= use_cnt_next;
            fonly_reg   <= in_data.frame_only;
            a_min_p_reg <= a_min_p_next;
            a_sec_p_reg <= a_sec_p_next;
            a_frm_p_reg <= a_frm_p_next;
            a_smp_reg   <= a_smp_next;
            b_min_p_reg <= b_min_p_next;
            b_sec_p_reg <= b_sec_p_next;
            b_frm_p_reg <= b_frm_p_next;
            b_smp_reg   <= b_smp_next;
            cnt_q_reg   <= cnt_q_next;
            cnt_reg     <= in_data.sample_count;
        end
        if (en2)
            lin_reg <= lin_next;
    end

endmodule

// ----- hw/rtl/cd_msf_red.sv -----
// cd_msf_red: adds or subtracts the linear operands and folds the result into one period
// depends on cd_msf_pkg and cd_msf_time_add_sub_top_defines.svh
`include "cd_msf_time_add_sub_top_defines.svh"

module cd_msf_red (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cd_msf_pkg::lin_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output cd_msf_pkg::red_t out_data
);
    import cd_msf_pkg::*;

    logic en1;
    logic en2;
    logic v1_reg;
    logic v2_reg;

    logic [SUM_W-1:0] s_next;
    logic [SUM_W-1:0] s_reg;
    logic [SUM_W-1:0] c_m2p;
    logic [SUM_W-1:0] c_m1p;
    logic [SUM_W-1:0] c_p1p;
    logic [SUM_W-1:0] c_ofs1;
    logic [SUM_W-1:0] c_ofs2;
    red_t             red_next;
    red_t             red_reg;
    logic [LIN_W-1:0] s_low;
    logic             keep_in;
    logic             neg_chk;

    assign en2       = !v2_reg || out_ready;
    assign en1       = !v1_reg || en2;
    assign in_ready  = en1;
    assign out_valid = v2_reg;
    assign out_data  = red_reg;

    assign s_next = in_data.sub ? SUM_W'(in_data.left) - SUM_W'(in_data.right)
                                : SUM_W'(in_data.left) + SUM_W'(in_data.right);

    // candidates in two's complement, the msb is the sign
    always_comb
    begin
        c_m2p  = s_reg - SUM_W'(2 * PERIOD);
        c_m1p  = s_reg - SUM_W'(PERIOD);
        c_p1p  = s_reg + SUM_W'(PERIOD);
        c_ofs1 = s_reg + SUM_W'(PERIOD + WRAP_OFS);
        c_ofs2 = s_reg + SUM_W'(2 * PERIOD + WRAP_OFS);
        if (!c_m2p[SUM_W-1])
        begin
            red_next.r    = LIN_W'(c_m2p);
            red_next.wrap = 1'b1;
        end
        else if (!c_m1p[SUM_W-1])
        begin
            red_next.r    = LIN_W'(c_m1p);
            red_next.wrap = 1'b1;
        end
        else if (!s_reg[SUM_W-1])
        begin
            red_next.r    = LIN_W'(s_reg);
            red_next.wrap = 1'b0;
        end
        else if (!c_p1p[SUM_W-1])
        begin
            red_next.r    = LIN_W'(c_p1p);
            red_next.wrap = 1'b1;
        end
        // borrow of more than a period: folded as a 64-bit wrap would be
        else if (!c_ofs1[SUM_W-1])
        begin
            red_next.r    = LIN_W'(c_ofs1);
            red_next.wrap = 1'b1;
        end
        else
        begin
            red_next.r    = LIN_W'(c_ofs2);
            red_next.wrap = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
            s_reg <= s_next;
        if (en2)
            red_reg <= red_next;
    end

    // a sum already inside one period passes unchanged; a negative one always wraps
    assign s_low   = LIN_W'(s_reg);
    assign keep_in = v1_reg && !s_reg[SUM_W-1] && (s_reg < SUM_W'(PERIOD));
    assign neg_chk = en2 && v1_reg && s_reg[SUM_W-1];

    `CD_MSF_ASSERT_NOW(a_red_in_period, clk, rst_n, out_valid, out_data.r < LIN_W'(PERIOD))
    `CD_MSF_ASSERT_NOW(a_red_no_fold, clk, rst_n, keep_in, !red_next.wrap && red_next.r == s_low)
    `CD_MSF_ASSERT_NEXT(a_red_neg_wraps, clk, rst_n, neg_chk, red_reg.wrap)

endmodule

// ----- hw/rtl/cd_msf_split.sv -----
// cd_msf_split: splits a linear position into minute, second, frame and sample digits
// depends on cd_msf_pkg and cd_msf_time_add_sub_top_defines.svh
`include "cd_msf_time_add_sub_top_defines.svh"

module cd_msf_split (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cd_msf_pkg::red_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output cd_msf_pkg::res_t out_data
);
    import cd_msf_pkg::*;

    logic en1;
    logic en2;
    logic v1_reg;
    logic v2_reg;

    logic [MIN_PROD_W-1:0] min_prod;
    logic [SEC_PROD_W-1:0] sec_prod;
    logic [FRM_PROD_W-1:0] frm_prod;
    logic [MIN_W-1:0]      minute_reg;
    logic [TOTSEC_W-1:0]   totsec_reg;
    logic [TOTFRM_W-1:0]   totfrm_reg;
    logic [LIN_W-1:0]      r_reg;
    logic                  wrap_reg;
    res_t                  res_next;
    res_t                  res_reg;
    logic                  sec_ok;
    logic                  frm_ok;
    logic                  smp_ok;

    assign en2       = !v2_reg || out_ready;
    assign en1       = !v1_reg || en2;
    assign in_ready  = en1;
    assign out_valid = v2_reg;
    assign out_data  = res_reg;

    // whole minutes, whole seconds and whole frames, all from the same value
    always_comb
    begin
        min_prod = MIN_PROD_W'(in_data.r[LIN_W-1:MDIV_SH]) * MIN_PROD_W'(RCP_MIN);
        sec_prod = SEC_PROD_W'(in_data.r[LIN_W-1:QDIV_SH]) * SEC_PROD_W'(RCP_SEC);
        frm_prod = FRM_PROD_W'(in_data.r[LIN_W-1:QDIV_SH]) * FRM_PROD_W'(RCP_FRM);
    end

    // remainders only need the low bits of each difference
    always_comb
    begin
        res_next.minute = minute_reg;
        res_next.second = SEC_W'(totsec_reg
                                 - TOTSEC_W'(minute_reg) * TOTSEC_W'(SECONDS_PER_MINUTE));
        res_next.frame  = FRM_W'(totfrm_reg
                                 - TOTFRM_W'(totsec_reg) * TOTFRM_W'(FRAMES_PER_SECOND));
        res_next.sample = SMP_W'(r_reg - LIN_W'(totfrm_reg) * LIN_W'(SAMPLES_PER_FRAME));
        res_next.wrap   = wrap_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            minute_reg <= min_prod[RCP_MIN_SH +: MIN_W];
            totsec_reg <= sec_prod[RCP_SEC_SH +: TOTSEC_W];
            totfrm_reg <= frm_prod[RCP_FRM_SH +: TOTFRM_W];
            r_reg      <= in_data.r;
            wrap_reg   <= in_data.wrap;
        end
        if (en2)
            res_reg <= res_next;
    end

    assign sec_ok = out_data.second < SEC_W'(SECONDS_PER_MINUTE);
    assign frm_ok = out_data.frame < FRM_W'(FRAMES_PER_SECOND);
    assign smp_ok = out_data.sample < SMP_W'(SAMPLES_PER_FRAME);

    `CD_MSF_ASSERT_NOW(a_split_second, clk, rst_n, out_valid, sec_ok)
    `CD_MSF_ASSERT_NOW(a_split_frame, clk, rst_n, out_valid, frm_ok)
    `CD_MSF_ASSERT_NOW(a_split_sample, clk, rst_n, out_valid, smp_ok)

endmodule

// ----- hw/rtl/cd_msf_time_add_sub_top.sv -----
// cd_msf_time_add_sub_top: msf disc position add and subtract, six-stage pipeline
// depends on cd_msf_pkg, cd_msf_lin, cd_msf_red and cd_msf_split
//
//  port     dir  tdata                                     tuser
//  s_axis   in   a position, b position, sample_count      op, frame_only
//  m_axis   out  res minute, second, frame, sample         wrapped
//
// one transaction per cycle sustained while m_axis_tready is high; two register stages
// in each of linearise, add and fold, and digit split
// rst_n clears the valid bits only; nothing needs clearing, so input is taken at once
// a stage loads whenever it is empty or its successor moves, so m_axis_tready low
// fills the bubbles first and then stops s_axis_tready
module cd_msf_time_add_sub_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // a_minute, a_second, a_frame, a_sample, b_minute, b_second, b_frame,
    // b_sample, sample_count, zero pad
    input  logic [95:0] s_axis_tdata,
    // op, frame_only
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // res_minute, res_second, res_frame, res_sample, zero pad
    output logic [31:0] m_axis_tdata,
    // wrapped
    output logic [0:0]  m_axis_tuser
);
    import cd_msf_pkg::*;

    in_t  in_data;
    lin_t lin_data;
    red_t red_data;
    res_t res_data;
    logic lin_valid;
    logic lin_ready;
    logic red_valid;
    logic red_ready;

    always_comb
    begin
        in_data.op           = s_axis_tuser[1:0];
        in_data.frame_only   = s_axis_tuser[2];
        in_data.a_minute     = s_axis_tdata[7:0];
        in_data.a_second     = s_axis_tdata[13:8];
        in_data.a_frame      = s_axis_tdata[20:14];
        in_data.a_sample     = s_axis_tdata[30:21];
        in_data.b_minute     = s_axis_tdata[38:31];
        in_data.b_second     = s_axis_tdata[44:39];
        in_data.b_frame      = s_axis_tdata[51:45];
        in_data.b_sample     = s_axis_tdata[61:52];
        in_data.sample_count = s_axis_tdata[89:62];
    end

    cd_msf_lin u_lin (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (in_data),
        .out_valid (lin_valid),
        .out_ready (lin_ready),
        .out_data  (lin_data)
    );

    cd_msf_red u_red (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lin_valid),
        .in_ready  (lin_ready),
        .in_data   (lin_data),
        .out_valid (red_valid),
        .out_ready (red_ready),
        .out_data  (red_data)
    );

    cd_msf_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (red_valid),
        .in_ready  (red_ready),
        .in_data   (red_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res_data)
    );

    assign m_axis_tdata = {1'b0, res_data.sample, res_data.frame, res_data.second,
                           res_data.minute};
    assign m_axis_tuser = res_data.wrap;

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for the msf disc position add/subtract block
// predicts each result from the input transaction and checks the output stream in order
// depends on cd_msf_pkg and cd_msf_time_add_sub_top
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cd_msf_pkg::*;

    localparam int RANDOM_ITEMS    = 1430;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int SETTLE_CYCLES   = 16;

    // keeps the expected results in order and checks each output transaction
    class msf_result_board;
        res_t        pending_results[$];
        int unsigned mismatches;

        function longint unsigned linear_pos(longint unsigned m, longint unsigned s,
                                             longint unsigned f, longint unsigned smp);
            return m * SAMPLES_PER_MINUTE + s * SAMPLES_PER_SECOND
                   + f * SAMPLES_PER_FRAME + smp;
        endfunction

        function res_t compute_msf(in_t it);
            longint unsigned left;
            longint unsigned right;
            longint unsigned total;
            logic            wrap;
            res_t            r;
            left = linear_pos(it.a_minute, it.a_second, it.a_frame,
                              it.frame_only ? 0 : it.a_sample);
            if (it.op == OP_ADD_POS || it.op == OP_SUB_POS)
            begin
                right = linear_pos(it.b_minute, it.b_second, it.b_frame,
                                   it.frame_only ? 0 : it.b_sample);
            end
            else
            begin
                right = it.sample_count;
                if (it.frame_only)
                    right = (right / SAMPLES_PER_FRAME) * SAMPLES_PER_FRAME;
            end
            if (it.op == OP_ADD_POS || it.op == OP_ADD_CNT)
            begin
                total = left + right;
                wrap  = total >= PERIOD;
                total = total % PERIOD;
            end
            else if (left >= right)
            begin
                total = left - right;
                wrap  = total >= PERIOD;
                total = total % PERIOD;
            end
            else
            begin
                // borrow out of the minute digit; a gap above one period wraps modulo 2^64
                total = PERIOD - (right - left);
                wrap  = 1'b1;
            end
            r.minute = MIN_W'(total / SAMPLES_PER_MINUTE);
            r.second = SEC_W'((total / SAMPLES_PER_SECOND) % SECONDS_PER_MINUTE);
            r.frame  = FRM_W'((total / SAMPLES_PER_FRAME) % FRAMES_PER_SECOND);
            r.sample = SMP_W'(total % SAMPLES_PER_FRAME);
            r.wrap   = wrap;
            return r;
        endfunction

        function void note_operation(in_t it);
            pending_results.push_back(compute_msf(it));
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d:%0d:%0d:%0d wrap %0b",
                             got.minute, got.second, got.frame, got.sample, got.wrap);
                return;
            end
            want = pending_results.pop_front();
            if (got.minute !== want.minute || got.second !== want.second ||
                got.frame !== want.frame || got.sample !== want.sample ||
                got.wrap !== want.wrap)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d:%0d:%0d:%0d/%0b got %0d:%0d:%0d:%0d/%0b",
                             want.minute, want.second, want.frame, want.sample, want.wrap,
                             got.minute, got.second, got.frame, got.sample, got.wrap);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    msf_result_board board = new();
    // raised by the sender only; the receiver keeps its own count of hold-offs served
    int unsigned     hold_off_reqs = 0;

    cd_msf_time_add_sub_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic in_t make_item(logic [OP_W-1:0] op, bit fo,
                                      int am, int as, int af, int asp,
                                      int bm, int bs, int bf, int bsp, int cnt);
        in_t it;
        it.op           = op;
        it.frame_only   = fo;
        it.a_minute     = MIN_W'(am);
        it.a_second     = SEC_W'(as);
        it.a_frame      = FRM_W'(af);
        it.a_sample     = SMP_W'(asp);
        it.b_minute     = MIN_W'(bm);
        it.b_second     = SEC_W'(bs);
        it.b_frame      = FRM_W'(bf);
        it.b_sample     = SMP_W'(bsp);
        it.sample_count = CNT_W'(cnt);
        return it;
    endfunction

    function automatic int pick_minute();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 255;
            2: return $urandom_range(250, 255);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic in_t random_item();
        in_t          it;
        logic [95:0]  raw;
        raw = {$urandom, $urandom, $urandom};
        if ($urandom_range(0, 9) == 0)
        begin
            // any bit pattern, out of range digits included
            it = raw[$bits(in_t)-1:0];
        end
        else
        begin
            it = make_item(OP_W'($urandom_range(0, 3)), $urandom_range(0, 3) == 0,
                           pick_minute(), $urandom_range(0, 59), $urandom_range(0, 74),
                           $urandom_range(0, 587),
                           pick_minute(), $urandom_range(0, 59), $urandom_range(0, 74),
                           $urandom_range(0, 587), 0);
            case ($urandom_range(0, 3))
                0: it.sample_count = CNT_W'($urandom_range(0, 32'(3 * SAMPLES_PER_MINUTE)));
                1: it.sample_count = {CNT_W{1'b1}} - CNT_W'($urandom_range(0, 2000));
                default: it.sample_count = raw[95:96-CNT_W];
            endcase
        end
        return it;
    endfunction

    task automatic send_item(input in_t it);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, it.sample_count, it.b_sample, it.b_frame, it.b_second,
                          it.b_minute, it.a_sample, it.a_frame, it.a_second, it.a_minute};
        s_axis_tuser  <= {it.frame_only, it.op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_operation(it);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // output side: checks every transaction taken at a clock edge
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.minute = m_axis_tdata[7:0];
            got.second = m_axis_tdata[13:8];
            got.frame  = m_axis_tdata[20:14];
            got.sample = m_axis_tdata[30:21];
            got.wrap   = m_axis_tuser[0];
            board.check_result(got);
        end
    end

    // receiver: stall patterns of its own, plus one long hold-off on request
    initial
    begin : receiver
        int unsigned mode;
        int          len;
        int unsigned rx_cycle;
        int unsigned holds_done;
        rx_cycle   = 0;
        holds_done = 0;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off_reqs != holds_done)
            begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(4, 60);
                for (int i = 0; i < len && hold_off_reqs == holds_done; i++)
                begin
                    case (mode)
                        0: m_axis_tready <= 1'b1;
                        1: m_axis_tready <= (rx_cycle % 3) != 2;
                        2: m_axis_tready <= 1'($urandom_range(0, 1));
                        default: m_axis_tready <= (i % 8) >= 5;
                    endcase
                    rx_cycle++;
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        int burst_left;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        rst_n         <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: digit extremes, every op, borrows and carries out of the minute digit
        send_item(make_item(OP_ADD_POS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_ADD_POS, 0, 255, 59, 74, 587, 0, 0, 0, 1, 0));
        send_item(make_item(OP_SUB_POS, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
        send_item(make_item(OP_SUB_POS, 0, 17, 33, 40, 300, 17, 33, 40, 300, 0));
        send_item(make_item(OP_ADD_POS, 0, 255, 59, 74, 587, 255, 59, 74, 587, 0));
        send_item(make_item(OP_ADD_POS, 0, 0, 63, 127, 1023, 0, 63, 127, 1023, 0));
        // left beyond a full period, then a right operand beyond a period
        send_item(make_item(OP_SUB_POS, 0, 255, 63, 127, 1023, 0, 0, 0, 0, 0));
        send_item(make_item(OP_SUB_POS, 0, 0, 0, 0, 0, 255, 63, 127, 1023, 0));
        send_item(make_item(OP_ADD_CNT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 28'hFFF_FFFF));
        send_item(make_item(OP_SUB_CNT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 28'hFFF_FFFF));
        send_item(make_item(OP_SUB_CNT, 0, 12, 34, 56, 300, 0, 0, 0, 0, 587));
        // frame-only: sample digits and the sub-frame part of the count drop out
        send_item(make_item(OP_ADD_CNT, 1, 5, 5, 5, 587, 0, 0, 0, 0, 587));
        send_item(make_item(OP_SUB_CNT, 1, 0, 0, 1, 100, 0, 0, 0, 0, 1175));
        send_item(make_item(OP_ADD_POS, 1, 1, 2, 3, 587, 4, 5, 6, 587, 0));
        send_item(make_item(OP_SUB_POS, 1, 0, 0, 0, 200, 0, 0, 0, 400, 0));
        // unused operand fields set to all ones
        send_item(make_item(OP_ADD_CNT, 0, 3, 4, 5, 6, 255, 63, 127, 1023, 1000));
        send_item(make_item(OP_SUB_POS, 0, 9, 8, 7, 6, 1, 2, 3, 4, 28'hFFF_FFFF));
        send_item(make_item(OP_ADD_CNT, 0, 255, 59, 74, 587, 0, 0, 0, 0, 1));
        send_item(make_item(OP_SUB_CNT, 1, 0, 0, 0, 0, 0, 0, 0, 0, 28'hFFF_FFFF));
        send_item(make_item(OP_ADD_POS, 1, 255, 59, 74, 0, 0, 0, 1, 0, 0));
        drain_results();

        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 400)
            begin
                // long output hold-off while input keeps coming, so the pipeline fills
                hold_off_reqs++;
                burst_left = 250;
            end
            if (n == 900)
                drain_results();
            if (burst_left == 0)
            begin
                idle_for(($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(1, 5));
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(1, 12);
            end
            send_item(random_item());
            burst_left--;
        end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (board.mismatches == 0 && board.pending_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin : watchdog
        #(5_000_000);
        $display("tb_top: errors");
        $finish;
    end

endmodule
